// ===== rtl/mlfo_pkg.sv =====
package mlfo_pkg;

	localparam int DEF_INSTANCES       = 256;
	localparam int DEF_PHASE_BITS      = 24;
	localparam int DEF_SAMPLE_BITS     = 16;
	localparam int DEF_SINE_TABLE_BITS = 10;

	localparam int IN_DATA_W   = 56;
	localparam int IN_USER_W   = 4;
	localparam int INST_LSB    = 0;
	localparam int INST_W      = 8;
	localparam int PHASE_LSB   = 8;
	localparam int PHASE_W     = 24;
	localparam int STEP_LSB    = 32;
	localparam int STEP_W      = 24;
	localparam int WAVE_LSB    = 0;
	localparam int WAVE_W      = 3;
	localparam int RESTART_BIT = 3;

	localparam int SEED_W = 32;
	localparam int WORD_W = SEED_W + 1;

	localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd0;
	localparam logic [WAVE_W-1:0] WAVE_RAMP   = 3'd1;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd2;
	localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd3;
	localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd4;
	localparam logic [WAVE_W-1:0] WAVE_NOISE  = 3'd5;

	localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD   = 32'd1013904223;
	localparam logic [SEED_W-1:0] LCG_START = 32'h12345678;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		int i;
		quo = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [31:0] sine_entry(input int unsigned k, input int unsigned tbits,
			input int unsigned sbits);
		longint unsigned a;
		longint unsigned term;
		longint unsigned scaled;
		longint unsigned half;
		longint unsigned top;
		longint sum;
		int unsigned n;
		a = (64'(k) * HALF_PI_Q30) >> tbits;
		term = a;
		sum = signed'(a);
		for (n = 1; n <= 7; n++) begin
			term = (term * a) >> 30;
			term = (term * a) >> 30;
			term = div_u64(term, 64'(2 * n) * 64'(2 * n + 1));
			if (n[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		half = 64'd1 << (sbits - 1);
		top = half - 64'd1;
		scaled = (unsigned'(sum) * half + (64'd1 << 29)) >> 30;
		return 32'(scaled > top ? top : scaled);
	endfunction

endpackage

// ===== rtl/multiwave_lfo_sample_core.sv =====
// Pipeline: an item passes the stage 1 registers, then the output register.
// Throughput: one transaction per cycle unless the output stalls; the seed
// memory is read on accept and written back as stage 1 advances, the last
// write forwarded to the next item. Reset: asynchronous, active low; afterwards
// a clearing pass zeroes every seeded flag in memory, accepting no input meanwhile.
module multiwave_lfo_sample_core #(
	parameter int INSTANCES       = mlfo_pkg::DEF_INSTANCES,
	parameter int PHASE_BITS      = mlfo_pkg::DEF_PHASE_BITS,
	parameter int SAMPLE_BITS     = mlfo_pkg::DEF_SAMPLE_BITS,
	parameter int SINE_TABLE_BITS = mlfo_pkg::DEF_SINE_TABLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mlfo_pkg::IN_DATA_W-1:0]       s_tdata,  // instance_req, phase, phase_step
	input  logic [mlfo_pkg::IN_USER_W-1:0]       s_tuser,  // wave_select, restart
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata   // sample, zero fill
);

	import mlfo_pkg::*;

	localparam int AW    = INSTANCES > 1 ? $clog2(INSTANCES) : 1;
	localparam int SB    = SAMPLE_BITS;
	localparam int QB    = SINE_TABLE_BITS;
	localparam int WANT  = QB + 2;
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam logic signed [SB+1:0] HALF_S = signed'((SB + 2)'(1) << (SB - 1));
	localparam logic signed [SB+1:0] TOP_S  = HALF_S - (SB + 2)'(1);
	localparam logic [QB:0] QLEN = (QB + 1)'(1) << QB;

	// input side
	logic [INST_W-1:0]     inst_in;
	logic [PHASE_W-1:0]    phase_in;
	logic [STEP_W-1:0]     step_in;
	logic [WAVE_W-1:0]     wave_in;
	logic                  restart_in;
	logic [PHASE_BITS-1:0] p_in;
	logic [SB-1:0]         t_in;
	logic [WANT-1:0]       idx_in;
	logic [QB:0]           rom_addr;
	logic [31:0]           inst_ext;
	logic                  in_range_in;
	logic                  accept;

	assign inst_in    = s_tdata[INST_LSB +: INST_W];
	assign phase_in   = s_tdata[PHASE_LSB +: PHASE_W];
	assign step_in    = s_tdata[STEP_LSB +: STEP_W];
	assign wave_in    = s_tuser[WAVE_LSB +: WAVE_W];
	assign restart_in = s_tuser[RESTART_BIT];
	assign p_in       = PHASE_BITS'(phase_in);
	assign inst_ext   = 32'(inst_in);
	assign in_range_in = inst_ext < 32'(INSTANCES);

	if (PHASE_BITS >= SB) begin : g_t_trunc
		assign t_in = p_in[PHASE_BITS-1 -: SB];
	end else begin : g_t_ext
		assign t_in = {p_in, {(SB - PHASE_BITS){1'b0}}};
	end

	if (PHASE_BITS >= WANT) begin : g_idx_trunc
		assign idx_in = p_in[PHASE_BITS-1 -: WANT];
	end else begin : g_idx_ext
		assign idx_in = {p_in, {(WANT - PHASE_BITS){1'b0}}};
	end

	assign rom_addr = idx_in[QB] ? QLEN - {1'b0, idx_in[QB-1:0]} : {1'b0, idx_in[QB-1:0]};

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == AW'(INSTANCES - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// stage 1
	logic              s1_valid_q;
	logic [AW-1:0]     inst_s1;
	logic              in_range_s1;
	logic              stopped_s1;
	logic [WAVE_W-1:0] wave_s1;
	logic              restart_s1;
	logic [SB-1:0]     t_s1;
	logic              neg_s1;
	logic              s1_adv;
	logic              m_tvalid_q;
	logic [SB-1:0]     sample_s2;

	assign s1_adv   = !m_tvalid_q || m_tready;
	assign s_tready = !clearing_q && (!s1_valid_q || s1_adv);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inst_s1     <= inst_ext[AW-1:0];
			in_range_s1 <= in_range_in;
			stopped_s1  <= step_in == '0;
			wave_s1     <= wave_in;
			restart_s1  <= restart_in;
			t_s1        <= t_in;
			neg_s1      <= idx_in[QB+1];
		end
	end

	// memories
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic [SB-1:0]     rom_data;

	mlfo_ram #(
		.WIDTH(WORD_W),
		.DEPTH(INSTANCES)
	) u_seed_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(inst_ext[AW-1:0]),
		.rdata(ram_rdata)
	);

	mlfo_sine_rom #(
		.TABLE_BITS(QB),
		.DATA_BITS (SB)
	) u_sine_rom (
		.clk (clk),
		.en  (accept),
		.addr(rom_addr),
		.data(rom_data)
	);

	// seed read-modify-write
	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	logic [WORD_W-1:0] fwd_word_q;
	logic [WORD_W-1:0] word_cur;
	logic              flag_eff;
	logic [SEED_W-1:0] seed_cur;
	logic [SEED_W-1:0] base;
	logic [SEED_W-1:0] lcg_next;
	logic [SEED_W-1:0] seed_new;
	logic              is_noise;
	logic              wr_en_s1;
	logic [WORD_W-1:0] wr_word;

	assign word_cur = (fwd_valid_q && fwd_addr_q == inst_s1) ? fwd_word_q : ram_rdata;
	assign flag_eff = word_cur[SEED_W] && !restart_s1;
	assign seed_cur = word_cur[SEED_W-1:0];
	assign base     = flag_eff ? seed_cur : LCG_START;
	assign lcg_next = base * LCG_MUL + LCG_ADD;
	assign seed_new = (stopped_s1 && flag_eff) ? seed_cur : lcg_next;
	assign is_noise = wave_s1 == WAVE_NOISE;
	assign wr_en_s1 = s1_valid_q && s1_adv && in_range_s1 && (is_noise || restart_s1);
	assign wr_word  = is_noise ? {1'b1, seed_new} : {1'b0, seed_cur};

	assign ram_we    = clearing_q || wr_en_s1;
	assign ram_waddr = clearing_q ? clr_q : inst_s1;
	assign ram_wdata = clearing_q ? '0 : wr_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			fwd_addr_q <= inst_s1;
			fwd_word_q <= wr_word;
		end
	end

	// waveform map
	logic signed [SB+1:0] t_sx;
	logic signed [SB+1:0] dev;
	logic signed [SB+1:0] dev_abs;
	logic signed [SB+1:0] sine_sx;
	logic [SB-1:0]        noise;
	logic signed [SB+1:0] v;
	logic signed [SB+1:0] v_clip;
	logic [SB-1:0]        sample;

	assign t_sx    = signed'({2'b00, t_s1});
	assign dev     = t_sx - HALF_S;
	assign dev_abs = dev < 0 ? -dev : dev;
	assign sine_sx = signed'({2'b00, rom_data});
	assign noise   = {~seed_new[SEED_W-1], seed_new[SEED_W-2 -: SB-1]};

	always_comb begin
		case (wave_s1)
			WAVE_RAMP:   v = dev;
			WAVE_SQUARE: v = t_s1[SB-1] ? -HALF_S : TOP_S;
			WAVE_TRI:    v = HALF_S - (dev_abs <<< 1);
			WAVE_SINE:   v = neg_s1 ? -sine_sx : sine_sx;
			WAVE_NOISE:  v = signed'({{2{noise[SB-1]}}, noise});
			default:     v = HALF_S - t_sx;
		endcase
	end

	assign v_clip = v > TOP_S ? TOP_S : v;
	assign sample = in_range_s1 ? v_clip[SB-1:0] : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_adv) begin
			m_tvalid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			sample_s2 <= sample;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(sample_s2);

	assert property (@(posedge clk) disable iff (!arst_n) !(clearing_q && s1_valid_q))
		else $error("item in flight during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_adv && in_range_s1 && is_noise) |-> (ram_we && ram_wdata[SEED_W]))
		else $error("noise item did not mark instance seeded");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clearing_q) |=> (fwd_valid_q && fwd_word_q == $past(ram_wdata)))
		else $error("forward register missed a write-back");

	assert property (@(posedge clk) disable iff (!arst_n) $rose(m_tvalid) |-> $past(s1_valid_q))
		else $error("result without a stage 1 item");

endmodule

// ===== rtl/mlfo_ram.sv =====
module mlfo_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mlfo_sine_rom.sv =====
module mlfo_sine_rom #(
	parameter int TABLE_BITS = mlfo_pkg::DEF_SINE_TABLE_BITS,
	parameter int DATA_BITS  = mlfo_pkg::DEF_SAMPLE_BITS
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [TABLE_BITS:0]  addr,
	output logic [DATA_BITS-1:0] data
);

	import mlfo_pkg::*;

	localparam int ENTRIES = (1 << TABLE_BITS) + 1;

	logic [DATA_BITS-1:0] tab [ENTRIES];
	logic [DATA_BITS-1:0] data_q;

	for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
		localparam logic [DATA_BITS-1:0] ENTRY = DATA_BITS'(sine_entry(k, TABLE_BITS, DATA_BITS));
		assign tab[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= tab[addr];
		end
	end

	assign data = data_q;

endmodule
